@@ hw/rtl/bbc_pkg.sv @@
// bbc_pkg: shared types and constants for the bollinger band calculator
// no dependencies

package bbc_pkg;

	localparam int SAMPLE_W = 24;
	localparam int BAND_W   = 30;
	localparam int WLEN_W   = 7;
	localparam int BSEL_W   = 2;
	localparam int WMUL_W   = 12;
	localparam int CFG_W    = 12;
	localparam int CIDX_W   = 2;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_BAND_SELECT      = 2'd1;
	localparam logic [CIDX_W-1:0] REG_WIDTH_MULTIPLIER = 2'd2;

	// band select codes
	localparam logic [BSEL_W-1:0] BAND_MIDDLE = 2'd0;
	localparam logic [BSEL_W-1:0] BAND_UPPER  = 2'd1;
	localparam logic [BSEL_W-1:0] BAND_LOWER  = 2'd2;

	// divider request from the sequencer; done comes back on a separate port
	typedef struct packed {
		logic        start;
		logic        neg;
		logic [63:0] num;
		logic [10:0] den;
	} div_req_t;

endpackage

@@ hw/rtl/bbc_divider.sv @@
// bbc_divider: restoring unsigned divider, one quotient bit per cycle
// depends on bbc_pkg (div_req_t); floor correction for negative numerators

module bbc_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  bbc_pkg::div_req_t req,
	output logic             done,
	output logic [63:0]      quot
);

	logic [63:0] num_q;
	logic [11:0] rem_q;
	logic [10:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [11:0] trial;

	always_comb begin
		trial = {rem_q[10:0], num_q[63]} - {1'b0, den_q};
	end

	// shift-subtract loop, 64 iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= req.num;
				den_q  <= req.den;
				neg_q  <= req.neg;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (!trial[11]) begin
					rem_q <= trial;
					num_q <= {num_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[10:0], num_q[63]};
					num_q <= {num_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// magnitude quotient; negate with floor rounding when the numerator was negative
	always_ff @(posedge clk) begin
		if (busy_q && cnt_q == 7'd63) begin
			if (neg_q)
				quot <= -({num_q[62:0], ~trial[11]} + {63'd0, ((trial[11] ?
					{rem_q[10:0], num_q[63]} : trial) != 12'd0)});
			else
				quot <= {num_q[62:0], ~trial[11]};
		end
	end

endmodule

@@ hw/rtl/bollinger_band_calc.sv @@
// bollinger_band_calc: top level, sample ring memory and sequencer
// depends on bbc_pkg and bbc_divider
//
// channel  | dir | fields
// s_axis   | in  | tdata[23:0] sample
// m_axis   | out | tdata[29:0] band_value, tuser band_valid
// cfg      | in  | 0 window_length, 1 band_select, 2 width_multiplier
//
// each accepted sample runs two walks over the ring memory (one read per
// cycle), the mean and variance divides (one bit per cycle), a bitwise
// square root and the multiply, band and output steps before m_axis_tvalid
// rises. a sample that leaves the window short goes straight to the output
// step and skips the walks, divides and root.
// reset clears the state, pointers and fill count; the ring needs no clearing.
// a stalled output holds the next sample off at s_axis.

module bollinger_band_calc #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [23:0]                s_axis_tdata,   // [23:0] sample
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [31:0]                m_axis_tdata,   // [29:0] band_value
	output logic                       m_axis_tuser,   // [0] band_valid
	input  logic                       cfg_we,
	input  logic [bbc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [bbc_pkg::CFG_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SUM, ST_MDIV, ST_MWAIT, ST_SSD, ST_VDIV, ST_VWAIT,
		ST_SQRT, ST_MUL, ST_BAND, ST_OUT
	} state_t;

	state_t state_q;

	logic [bbc_pkg::WLEN_W-1:0] wlen_q;
	logic [bbc_pkg::BSEL_W-1:0] bsel_q;
	logic [bbc_pkg::WMUL_W-1:0] wmul_q;

	logic [23:0]   ring [MAX_WINDOW];
	logic [23:0]   rd_s1;
	logic [AW-1:0] wpos_q, rpos_q;
	logic [CW-1:0] fill_q, len_q, cnt_q;
	logic          rd_vld_q;

	logic signed [39:0] sum_q;
	logic signed [33:0] mean_q;
	logic [63:0]        ssd_q;
	logic [63:0]        rad_q, res_q, bit_q;
	logic [31:0]        sd_q;
	logic [43:0]        wprod_q;
	logic [29:0]        band_q;
	logic               bval_q;

	bbc_pkg::div_req_t  dreq;
	logic               ddone;
	logic [63:0]        dquot;

	logic [CW-1:0] len_eff;
	logic [CW-1:0] fill_nx;
	logic signed [34:0] diff;
	logic [24:0]        adiff;
	logic [49:0]        sq;
	logic [63:0]        sq_try;

	// clamp window length to 1..MAX_WINDOW
	always_comb begin
		if (wlen_q == '0)
			len_eff = CW'(1);
		else if (32'(wlen_q) > MAX_WINDOW)
			len_eff = CW'(MAX_WINDOW);
		else
			len_eff = CW'(wlen_q);
		fill_nx = (32'(fill_q) < MAX_WINDOW) ? fill_q + CW'(1) : fill_q;
	end

	// deviation magnitude fits 25 bits, so its square fits 50
	always_comb begin
		diff   = 35'(signed'(rd_s1)) - 35'(mean_q);
		adiff  = diff[34] ? 25'(-diff) : 25'(diff);
		sq     = adiff * adiff;
		sq_try = res_q + bit_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= 7'd20;
			bsel_q <= bbc_pkg::BAND_MIDDLE;
			wmul_q <= 12'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				bbc_pkg::REG_WINDOW_LENGTH:    wlen_q <= cfg_data[bbc_pkg::WLEN_W-1:0];
				bbc_pkg::REG_BAND_SELECT:      bsel_q <= cfg_data[bbc_pkg::BSEL_W-1:0];
				bbc_pkg::REG_WIDTH_MULTIPLIER: wmul_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;

	// ring memory: one write and one registered read
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			ring[wpos_q] <= s_axis_tdata;
		rd_s1 <= ring[rpos_q];
	end

	// divider requests
	always_comb begin
		dreq.start = 1'b0;
		dreq.neg   = 1'b0;
		dreq.num   = '0;
		dreq.den   = 11'(len_q);
		if (state_q == ST_MDIV) begin
			dreq.start = 1'b1;
			dreq.neg   = sum_q[39];
			dreq.num   = sum_q[39] ? 64'(-sum_q) : 64'(sum_q);
		end else if (state_q == ST_VDIV) begin
			dreq.start = 1'b1;
			dreq.num   = ssd_q;
		end
	end

	bbc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.quot   (dquot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wpos_q        <= '0;
			rpos_q        <= '0;
			fill_q        <= '0;
			m_axis_tvalid <= 1'b0;
			rd_vld_q      <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						wpos_q <= (wpos_q == AW'(MAX_WINDOW - 1)) ? '0 : wpos_q + AW'(1);
						fill_q <= fill_nx;
						len_q  <= len_eff;
						rpos_q <= wpos_q;
						cnt_q  <= '0;
						sum_q  <= '0;
						ssd_q  <= '0;
						rd_vld_q <= 1'b0;
						if (fill_nx < len_eff) begin
							band_q <= '0;
							bval_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM, ST_SSD: begin
					// one read issued per cycle, its data registered for the next cycle
					if (cnt_q != len_q) begin
						rpos_q <= (rpos_q == '0) ? AW'(MAX_WINDOW - 1) : rpos_q - AW'(1);
						cnt_q  <= cnt_q + CW'(1);
					end
					rd_vld_q <= (cnt_q != len_q);
					if (rd_vld_q) begin
						if (state_q == ST_SUM)
							sum_q <= sum_q + 40'(signed'(rd_s1));
						else
							ssd_q <= ssd_q + 64'(sq);
					end
					if (cnt_q == len_q && !rd_vld_q)
						state_q <= (state_q == ST_SUM) ? ST_MDIV : ST_VDIV;
				end
				ST_MDIV: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (ddone) begin
						mean_q   <= 34'(signed'(dquot));
						rpos_q   <= (wpos_q == '0) ? AW'(MAX_WINDOW - 1) : wpos_q - AW'(1);
						cnt_q    <= '0;
						rd_vld_q <= 1'b0;
						state_q  <= ST_SSD;
					end
				end
				ST_VDIV: state_q <= ST_VWAIT;
				ST_VWAIT: begin
					if (ddone) begin
						rad_q   <= dquot;
						res_q   <= '0;
						bit_q   <= 64'd1 << 62;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					// bitwise integer square root, one result bit per cycle
					if (bit_q == '0) begin
						sd_q    <= res_q[31:0];
						state_q <= ST_MUL;
					end else begin
						if (rad_q >= sq_try) begin
							rad_q <= rad_q - sq_try;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				ST_MUL: begin
					wprod_q <= 44'(sd_q) * 44'(wmul_q);
					state_q <= ST_BAND;
				end
				ST_BAND: begin
					bval_q <= 1'b1;
					case (bsel_q)
						bbc_pkg::BAND_UPPER: band_q <= mean_q[29:0] + wprod_q[37:8];
						bbc_pkg::BAND_LOWER: band_q <= mean_q[29:0] - wprod_q[37:8];
						default:             band_q <= mean_q[29:0];
					endcase
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					m_axis_tvalid <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {2'b00, band_q};
	assign m_axis_tuser = bval_q;

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for bollinger_band_calc
// depends on bbc_pkg and the bollinger_band_calc rtl; reads no files

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// index past the last register, writes there must be ignored
	localparam logic [bbc_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [bbc_pkg::BSEL_W-1:0] BAND_SPARE = 2'd3;
	localparam int RING_DEPTH = 64;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 3000;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [bbc_pkg::BAND_W-1:0] value;
		logic                       valid;
	} band_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [bbc_pkg::SAMPLE_W-1:0] s_axis_tdata = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [31:0]                  m_axis_tdata;
	logic                         m_axis_tuser;
	logic                         cfg_we = 1'b0;
	logic [bbc_pkg::CIDX_W-1:0]   cfg_index = '0;
	logic [bbc_pkg::CFG_W-1:0]    cfg_data = '0;

	// predictor state and its copy of the registers
	logic signed [bbc_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
	int unsigned wpos = 0;
	int unsigned fill = 0;
	logic [bbc_pkg::WLEN_W-1:0] p_len = 7'd20;
	logic [bbc_pkg::BSEL_W-1:0] p_bsel = bbc_pkg::BAND_MIDDLE;
	logic [bbc_pkg::WMUL_W-1:0] p_mul = 12'd512;

	band_t band_q[$];
	int errors = 0;
	int samples_sent = 0;
	int bands_seen = 0;
	int valid_bands = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit no_idle = 0;
	int quiet_cycles = 0;

	bollinger_band_calc dut (.*);

	always #5 clk = ~clk;

	// band prediction for one accepted sample, updating the ring copy
	function automatic band_t compute_band(logic signed [bbc_pkg::SAMPLE_W-1:0] s);
		band_t r;
		longint l, sum, mean, d, bandv;
		longint unsigned ssd, var_q, sd, w, trial;
		int unsigned pos;
		r = '0;
		sum = 0;
		ssd = 0;
		sd = 0;
		l = (p_len == 0) ? 1 : (p_len > RING_DEPTH) ? RING_DEPTH : p_len;
		ring[wpos] = s;
		wpos = (wpos + 1) % RING_DEPTH;
		if (fill < RING_DEPTH)
			fill++;
		if (fill < l)
			return r;
		pos = wpos;
		for (int k = 0; k < l; k++) begin
			pos = (pos + RING_DEPTH - 1) % RING_DEPTH;
			sum += ring[pos];
		end
		mean = sum / l;
		if ((sum % l) != 0 && sum < 0)
			mean--;
		pos = wpos;
		for (int k = 0; k < l; k++) begin
			pos = (pos + RING_DEPTH - 1) % RING_DEPTH;
			d = ring[pos] - mean;
			ssd += longint'(d * d);
		end
		var_q = ssd / longint'(l);
		// integer square root, one result bit at a time
		for (int b = 26; b >= 0; b--) begin
			trial = sd | (64'd1 << b);
			if (trial * trial <= var_q)
				sd = trial;
		end
		w = (sd * p_mul) >> 8;
		case (p_bsel)
			bbc_pkg::BAND_UPPER: bandv = mean + longint'(w);
			bbc_pkg::BAND_LOWER: bandv = mean - longint'(w);
			default:             bandv = mean;
		endcase
		r.value = bandv[bbc_pkg::BAND_W-1:0];
		r.valid = 1'b1;
		return r;
	endfunction

	task automatic report(string what, band_t got, band_t want);
		errors++;
		$display("error %0t: %s got value %0d valid %0b, wanted value %0d valid %0b",
			$time, what, $signed(got.value), got.valid, $signed(want.value), want.valid);
	endtask

	// register write, block must be idle
	task automatic set_reg(logic [bbc_pkg::CIDX_W-1:0] idx, logic [bbc_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bbc_pkg::REG_WINDOW_LENGTH:    p_len = data[bbc_pkg::WLEN_W-1:0];
			bbc_pkg::REG_BAND_SELECT:      p_bsel = data[bbc_pkg::BSEL_W-1:0];
			bbc_pkg::REG_WIDTH_MULTIPLIER: p_mul = data[bbc_pkg::WMUL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(int len, int bsel, int mul);
		set_reg(bbc_pkg::REG_WINDOW_LENGTH, bbc_pkg::CFG_W'(len));
		set_reg(bbc_pkg::REG_BAND_SELECT, bbc_pkg::CFG_W'(bsel));
		set_reg(bbc_pkg::REG_WIDTH_MULTIPLIER, bbc_pkg::CFG_W'(mul));
	endtask

	// one sample transaction with a random gap in front
	task automatic send_sample(logic [bbc_pkg::SAMPLE_W-1:0] s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s;
		do
			@(posedge clk);
		while (!s_axis_tready);
		band_q.push_back(compute_band(s));
		samples_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (band_q.size() != 0)
			@(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [bbc_pkg::SAMPLE_W-1:0] random_sample(int shape);
		case (shape)
			0: return bbc_pkg::SAMPLE_W'($urandom);
			1: return bbc_pkg::SAMPLE_W'($urandom_range(0, 200) - 100);
			2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return bbc_pkg::SAMPLE_W'($urandom_range(0, 4000) + 1000000);
		endcase
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		band_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.value = m_axis_tdata[bbc_pkg::BAND_W-1:0];
			got.valid = m_axis_tuser;
			bands_seen++;
			if (got.valid)
				valid_bands++;
			if (band_q.size() == 0) begin
				report("unexpected band", got, '0);
			end else begin
				want = band_q.pop_front();
				if (got.value !== want.value)
					report("band_value", got, want);
				if (got.valid !== want.valid)
					report("band_valid", got, want);
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 15);
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("bollinger_band_calc: mismatch");
			$finish;
		end
	end

	// extremes on a one-sample window (zero length standing for one), then two samples and the spare band
	task automatic test_extremes();
		configure(0, bbc_pkg::BAND_UPPER, 4095);
		send_sample(24'h7fffff);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hffffff);
		drain();
		set_reg(bbc_pkg::REG_WINDOW_LENGTH, 12'd2);
		set_reg(bbc_pkg::REG_BAND_SELECT, bbc_pkg::BAND_LOWER);
		send_sample(24'h7fffff);
		send_sample(24'h800000);
		send_sample(24'h7fffff);
		drain();
		set_reg(bbc_pkg::REG_BAND_SELECT, BAND_SPARE);
		set_reg(bbc_pkg::REG_WIDTH_MULTIPLIER, 12'd0);
		send_sample(24'h123456);
		drain();
	endtask

	// oversize length clamps to the ring, a shorter window mid-run, an unused index, a full-ring window
	task automatic test_window_changes();
		configure(127, bbc_pkg::BAND_UPPER, 512);
		send_sample(24'h000100);
		send_sample(24'hffff00);
		send_sample(24'h000005);
		drain();
		set_reg(bbc_pkg::REG_WINDOW_LENGTH, 12'd3);
		send_sample(24'h000077);
		send_sample(24'hfff000);
		drain();
		// ignored write to an unused index
		set_reg(REG_UNUSED, 12'hfff);
		set_reg(bbc_pkg::REG_WINDOW_LENGTH, 12'd64);
		send_sample(24'h00abcd);
		drain();
	endtask

	// random phases over window length, band and multiplier
	task automatic test_random();
		int n, shape, len;
		for (int phase = 0; phase < 14; phase++) begin
			case ($urandom_range(0, 5))
				0: len = 64;
				1: len = $urandom_range(0, 1) ? 0 : 127;
				default: len = $urandom_range(1, 16);
			endcase
			configure(len, $urandom_range(0, 3),
				(phase == 0) ? 4095 : (phase == 1) ? 0 : $urandom_range(0, 4095));
			no_idle = (phase % 4 == 3);
			shape = $urandom_range(0, 3);
			n = $urandom_range(35, 50);
			repeat (n)
				send_sample(random_sample($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : shape));
			drain();
		end
		no_idle = 0;
	endtask

	// receiver stops for a long stretch while samples keep coming
	task automatic test_backpressure();
		configure(4, bbc_pkg::BAND_UPPER, 300);
		hold_left = HOLD_CYCLES;
		repeat (12)
			send_sample(random_sample(0));
		drain();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		// reset values: length 20, middle band, first 19 bands not yet valid
		repeat (22)
			send_sample(random_sample(1));
		drain();
		test_extremes();
		test_window_changes();
		test_backpressure();
		test_random();
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("sent %0d samples, checked %0d bands (%0d with a full window)",
			samples_sent, bands_seen, valid_bands);
		$display("covered window lengths 0..127, all band selects and multiplier extremes");
		if (errors == 0 && band_q.size() == 0) begin
			$display("bollinger_band_calc: match");
		end else begin
			$display("%0d errors, %0d bands outstanding", errors, band_q.size());
			$display("bollinger_band_calc: mismatch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_divider.sv
hw/rtl/bollinger_band_calc.sv
tb/tb.sv
